@@ sv/pkc_pkg.sv @@
// shared constants, request codes and controller/datapath interface structs
// for the pangram key cipher; no dependencies
package pkc_pkg;

  localparam int KEY_MAX = 64;
  localparam int ADDR_W  = $clog2(KEY_MAX);
  localparam int LEN_W   = 7;

  localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(KEY_MAX);
  localparam logic [7:0]       CHAR_UNDER = 8'h5F;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ENC  = 2'd1;
  localparam logic [1:0] REQ_DEC  = 2'd2;

  typedef struct packed {
    logic take;       // item transfer this cycle
    logic load_wr;    // write key byte
    logic enc_start;  // set up circular scan
    logic dec_start;  // decode in range, key read issued
    logic dec_under;  // decode out of range, emit underscore
    logic scan_en;    // advance scan pipeline
    logic emit_enc;   // register encode result
    logic emit_dec;   // register decode result from key read
  } pkc_cmd_t;

  typedef struct packed {
    logic letter;     // data byte is an ascii letter
    logic dec_ok;     // code number within key length
    logic hit;        // scan compare matched
    logic miss;       // last key byte compared without match
  } pkc_status_t;

endpackage

@@ sv/pangram_key_cipher.sv @@
// top level of the pangram key cipher: controller plus datapath
// depends on pkc_pkg, pkc_ctrl and pkc_dp
//
// usage: an item transfers at a rising edge where start is high and busy is
// low. in_req_type selects load key byte, encode byte or decode number;
// in_new_message clears the key position before the item is handled.
// load items write key slot in_key_index and give no result; busy stays low,
// so a load can follow every cycle. encode of a non-letter gives no result.
// encode of a letter scans the key circularly from the position, one key
// byte compared per cycle through the single key memory read port; busy
// stays high until the result is in. decode reads one key byte at the
// transfer edge and registers it as the result from the decode wait state;
// an out-of-range number registers the underscore at the transfer edge
// itself, so busy never rises for it.
// each result is on the out_ ports for exactly one cycle with out_valid high;
// the receiver cannot stall, and the next item may transfer in that cycle.
// cfg_we/cfg_wdata write key_length while idle, no read-back.
// reset (rst_n low, synchronous) clears the position and sets key_length to
// 64; the key table holds no defined contents until slots are loaded.
module pangram_key_cipher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic                        in_new_message,
  input  logic [pkc_pkg::ADDR_W-1:0]  in_key_index,
  input  logic [7:0]                  in_data_byte,
  input  logic [6:0]                  in_code_number,
  output logic                        out_valid,
  output logic [6:0]                  out_encoded_value,
  output logic [7:0]                  out_key_char,
  output logic [pkc_pkg::ADDR_W-1:0]  out_new_position,
  output logic                        out_was_decode,
  input  logic                        cfg_we,
  input  logic [pkc_pkg::LEN_W-1:0]   cfg_wdata
);
  import pkc_pkg::*;

  pkc_cmd_t    cmd;
  pkc_status_t sts;

  pkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  pkc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_new_message    (in_new_message),
    .in_key_index      (in_key_index),
    .in_data_byte      (in_data_byte),
    .in_code_number    (in_code_number),
    .out_valid         (out_valid),
    .out_encoded_value (out_encoded_value),
    .out_key_char      (out_key_char),
    .out_new_position  (out_new_position),
    .out_was_decode    (out_was_decode)
  );

endmodule

@@ sv/pkc_ctrl.sv @@
// controller state machine for the pangram key cipher
// depends on pkc_pkg for request codes and command/status structs
module pkc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          req_type,
  input  pkc_pkg::pkc_status_t sts,
  output logic                busy,
  output pkc_pkg::pkc_cmd_t   cmd
);
  import pkc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.take = 1'b1;
          unique case (req_type)
            REQ_LOAD: cmd.load_wr = 1'b1;
            REQ_ENC: begin
              if (sts.letter) begin
                cmd.enc_start = 1'b1;
                state_nxt     = ST_SCAN;
              end
            end
            REQ_DEC: begin
              if (sts.dec_ok) begin
                cmd.dec_start = 1'b1;
                state_nxt     = ST_DEC;
              end else begin
                cmd.dec_under = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts.hit || sts.miss) begin
          cmd.emit_enc = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      ST_DEC: begin
        cmd.emit_dec = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_dec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) |=> (state_r == ST_IDLE))
    else $error("decode wait lasted more than one cycle");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_enc, cmd.emit_dec, cmd.dec_under}))
    else $error("two results registered at once");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(cmd.take || cmd.load_wr || cmd.enc_start || cmd.dec_start))
    else $error("item transfer while busy");

  a_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_en && cmd.emit_enc))
    else $error("scan advanced while result registered");

endmodule

@@ sv/pkc_dp.sv @@
// datapath for the pangram key cipher: key memory, position, length register,
// pipelined circular scan and result registers; depends on pkc_pkg
module pkc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pkc_pkg::pkc_cmd_t           cmd,
  output pkc_pkg::pkc_status_t        sts,
  input  logic                        cfg_we,
  input  logic [pkc_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic                        in_new_message,
  input  logic [pkc_pkg::ADDR_W-1:0]  in_key_index,
  input  logic [7:0]                  in_data_byte,
  input  logic [6:0]                  in_code_number,
  output logic                        out_valid,
  output logic [6:0]                  out_encoded_value,
  output logic [7:0]                  out_key_char,
  output logic [pkc_pkg::ADDR_W-1:0]  out_new_position,
  output logic                        out_was_decode
);
  import pkc_pkg::*;

  logic [7:0]        key_mem [KEY_MAX];
  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] raddr;

  logic [LEN_W-1:0]  key_length_r;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] pos_r;
  logic [ADDR_W-1:0] pos0;
  logic [7:0]        byte_r;
  logic [7:0]        lower_byte;
  logic              is_upper, is_lower;

  logic [LEN_W:0]    dec_sum;
  logic [ADDR_W-1:0] dec_idx;

  logic [ADDR_W-1:0] iss_idx_r;
  logic [LEN_W-1:0]  iss_cnt_r;
  logic              iss_live;
  logic [ADDR_W-1:0] iss_idx_inc;
  logic              chk_v_r;
  logic [ADDR_W-1:0] chk_idx_r;
  logic [ADDR_W-1:0] chk_d_r;

  logic              out_valid_r;
  logic [6:0]        enc_val_r;
  logic [7:0]        dec_char_r;
  logic [ADDR_W-1:0] new_pos_r;
  logic              was_dec_r;

  // zero acts as one, anything above the table size as the table size
  always_comb begin
    if (key_length_r == '0) begin
      len = LEN_W'(1);
    end else if (key_length_r > LEN_W'(KEY_MAX)) begin
      len = LEN_W'(KEY_MAX);
    end else begin
      len = key_length_r;
    end
  end

  // stale position after a length change restarts at zero
  assign pos0 = (in_new_message || ({1'b0, pos_r} >= len)) ? '0 : pos_r;

  assign is_upper   = (in_data_byte >= 8'h41) && (in_data_byte <= 8'h5A);
  assign is_lower   = (in_data_byte >= 8'h61) && (in_data_byte <= 8'h7A);
  assign lower_byte = is_upper ? (in_data_byte | 8'h20) : in_data_byte;

  // pos0 < len and number <= len, so one subtract wraps
  always_comb begin
    dec_sum = {2'b00, pos0} + {1'b0, in_code_number};
    if (dec_sum >= {1'b0, len}) begin
      dec_sum = dec_sum - {1'b0, len};
    end
    dec_idx = dec_sum[ADDR_W-1:0];
  end

  assign iss_live    = (iss_cnt_r < len);
  assign iss_idx_inc = (({1'b0, iss_idx_r} + LEN_W'(1)) == len) ? '0 :
                       (iss_idx_r + ADDR_W'(1));

  assign raddr = cmd.dec_start ? dec_idx : iss_idx_r;

  assign sts.letter = is_upper || is_lower;
  assign sts.dec_ok = ({1'b0, in_code_number} <= {1'b0, len});
  assign sts.hit    = chk_v_r && (rdata_r == byte_r);
  assign sts.miss   = chk_v_r && (rdata_r != byte_r) &&
                      ({1'b0, chk_d_r} == (len - LEN_W'(1)));

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      key_mem[in_key_index] <= in_data_byte;
    end
    rdata_r <= key_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= LEN_RESET;
      pos_r        <= '0;
      chk_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_length_r <= cfg_wdata;
      end
      chk_v_r     <= cmd.scan_en && iss_live;
      out_valid_r <= cmd.emit_enc || cmd.emit_dec || cmd.dec_under;
      if (cmd.take) begin
        if (cmd.dec_start) begin
          pos_r <= dec_idx;
        end else if (cmd.dec_under) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos0;
        end
      end else if (cmd.emit_enc) begin
        pos_r <= sts.hit ? chk_idx_r : '0;
      end
    end
  end

  // scan pipeline: issue read, then compare against registered key data
  always_ff @(posedge clk) begin
    if (cmd.enc_start) begin
      byte_r    <= lower_byte;
      iss_idx_r <= pos0;
      iss_cnt_r <= '0;
    end else if (cmd.scan_en && iss_live) begin
      iss_idx_r <= iss_idx_inc;
      iss_cnt_r <= iss_cnt_r + LEN_W'(1);
    end
    if (cmd.scan_en) begin
      chk_idx_r <= iss_idx_r;
      chk_d_r   <= iss_cnt_r[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_enc) begin
      enc_val_r  <= sts.hit ? {1'b0, chk_d_r} : (len + LEN_W'(1));
      dec_char_r <= '0;
      new_pos_r  <= sts.hit ? chk_idx_r : '0;
      was_dec_r  <= 1'b0;
    end else if (cmd.emit_dec) begin
      enc_val_r  <= '0;
      dec_char_r <= rdata_r;
      new_pos_r  <= pos_r;
      was_dec_r  <= 1'b1;
    end else if (cmd.dec_under) begin
      enc_val_r  <= '0;
      dec_char_r <= CHAR_UNDER;
      new_pos_r  <= '0;
      was_dec_r  <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_encoded_value = enc_val_r;
  assign out_key_char      = dec_char_r;
  assign out_new_position  = new_pos_r;
  assign out_was_decode    = was_dec_r;

endmodule

@@ sim/tb.sv @@
// self-checking testbench for the pangram key cipher: key fill, directed table,
// then random traffic in phases with key length changes; depends on pkc_pkg
`timescale 1ns / 100ps

module tb;
  import pkc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SEG_ITEMS = 310;
  localparam int DRAIN_PAD = 80;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]        req;
    logic              nm;
    logic [ADDR_W-1:0] kidx;
    logic [7:0]        data;
    logic [6:0]        num;
  } cipher_req_t;

  typedef struct packed {
    logic [6:0]        enc;
    logic [7:0]        chr;
    logic [ADDR_W-1:0] pos;
    logic              dec;
  } cipher_res_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cipher_req_t rq;
    logic [6:0]  cfg_val;
    bit          typed;
    cipher_res_t res;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_req_type;
  logic              in_new_message;
  logic [ADDR_W-1:0] in_key_index;
  logic [7:0]        in_data_byte;
  logic [6:0]        in_code_number;
  logic              out_valid;
  logic [6:0]        out_encoded_value;
  logic [7:0]        out_key_char;
  logic [ADDR_W-1:0] out_new_position;
  logic              out_was_decode;
  logic              cfg_we;
  logic [LEN_W-1:0]  cfg_wdata;

  // shadow of the block state
  logic [7:0]  key_mem [KEY_MAX];
  int          cur_pos;
  int          cfg_len;

  cipher_res_t cipher_q[$];
  dir_row_t    dir_rows[$];
  int          err_count;
  int          checked;
  int          cycles;

  pangram_key_cipher uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_new_message    (in_new_message),
    .in_key_index      (in_key_index),
    .in_data_byte      (in_data_byte),
    .in_code_number    (in_code_number),
    .out_valid         (out_valid),
    .out_encoded_value (out_encoded_value),
    .out_key_char      (out_key_char),
    .out_new_position  (out_new_position),
    .out_was_decode    (out_was_decode),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic int eff_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > KEY_MAX) return KEY_MAX;
    return cfg_len;
  endfunction

  task automatic cipher_predict(input cipher_req_t r, output bit has_res,
                                output cipher_res_t res);
    int len;
    int idx;
    int span;
    int hit_pos;
    bit found;
    logic [7:0] ch;
    len = eff_len();
    has_res = 1'b0;
    res = '0;
    if (r.nm) cur_pos = 0;
    // position left over from a longer key
    if (cur_pos >= len) cur_pos = 0;
    case (r.req)
      REQ_LOAD: begin
        key_mem[r.kidx] = r.data;
      end
      REQ_ENC: begin
        if (is_letter(r.data)) begin
          ch = r.data;
          if (ch <= "Z") ch = ch + 8'd32;
          span = len + 1;
          found = 1'b0;
          hit_pos = 0;
          for (int d = 0; d < len; d++) begin
            idx = cur_pos + d;
            if (idx >= len) idx -= len;
            if (!found && key_mem[idx] == ch) begin
              found = 1'b1;
              span = d;
              hit_pos = idx;
            end
          end
          cur_pos = found ? hit_pos : 0;
          has_res = 1'b1;
          res.enc = 7'(span);
          res.pos = ADDR_W'(cur_pos);
          res.dec = 1'b0;
        end
      end
      REQ_DEC: begin
        if (r.num <= len) begin
          idx = cur_pos + r.num;
          if (idx >= len) idx -= len;
          res.chr = key_mem[idx];
          cur_pos = idx;
        end else begin
          res.chr = CHAR_UNDER;
          cur_pos = 0;
        end
        has_res = 1'b1;
        res.pos = ADDR_W'(cur_pos);
        res.dec = 1'b1;
      end
      default: ;
    endcase
  endtask

  // leaves start high; the caller lowers it if it wants a gap
  task automatic send_item(input cipher_req_t r, input bit typed, input cipher_res_t tres);
    bit has_res;
    cipher_res_t res;
    start          <= 1'b1;
    in_req_type    <= r.req;
    in_new_message <= r.nm;
    in_key_index   <= r.kidx;
    in_data_byte   <= r.data;
    in_code_number <= r.num;
    do @(posedge clk); while (busy);
    cipher_predict(r, has_res, res);
    if (has_res) cipher_q.insert(cipher_q.size(), typed ? tres : res);
  endtask

  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0 || busy) @(posedge clk);
    // extra padding once nothing is pending; non-letter encodes never start a scan
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [6:0] v);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_len = v;
  endtask

  function automatic dir_row_t item_row(input logic [1:0] req, input bit nm,
                                        input logic [5:0] kidx, input logic [7:0] data,
                                        input logic [6:0] num);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.rq = '{req: req, nm: nm, kidx: kidx, data: data, num: num};
    row.cfg_val = '0;
    row.typed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(input logic [1:0] req, input bit nm,
                                         input logic [7:0] data, input logic [6:0] num,
                                         input logic [6:0] enc, input logic [7:0] chr,
                                         input logic [5:0] pos, input bit dec);
    dir_row_t row;
    row = item_row(req, nm, '0, data, num);
    row.typed = 1'b1;
    row.res = '{enc: enc, chr: chr, pos: pos, dec: dec};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [6:0] v);
    dir_row_t row;
    row = item_row(REQ_LOAD, 1'b0, '0, '0, '0);
    row.kind = ROW_CFG;
    row.cfg_val = v;
    return row;
  endfunction

  function automatic void add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic cipher_req_t rand_request();
    cipher_req_t r;
    int sel;
    int len;
    len = eff_len();
    r = cipher_req_t'({$urandom, $urandom});
    r.nm = ($urandom_range(0, 99) < 8);
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      r.req = REQ_LOAD;
      if ($urandom_range(0, 99) < 60) r.data = 8'("a" + $urandom_range(0, 25));
    end else if (sel < 55) begin
      r.req = REQ_ENC;
      sel = $urandom_range(0, 99);
      if (sel < 45) r.data = 8'("a" + $urandom_range(0, 25));
      else if (sel < 80) r.data = 8'("A" + $urandom_range(0, 25));
    end else if (sel < 93) begin
      r.req = REQ_DEC;
      if ($urandom_range(0, 99) < 80) r.num = 7'($urandom_range(0, len));
    end else begin
      r.req = REQ_UNUSED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // results cannot be held off, so every strobe is a transfer
  always @(posedge clk) begin
    cipher_res_t want;
    if (rst_n && out_valid) begin
      if (cipher_q.size() == 0) begin
        $error("result with nothing expected: enc %0d chr %0h pos %0d dec %0b",
               out_encoded_value, out_key_char, out_new_position, out_was_decode);
        err_count++;
      end else begin
        want = cipher_q.pop_front();
        checked++;
        if (out_encoded_value !== want.enc) begin
          $error("encoded_value: expected %0d, got %0d", want.enc, out_encoded_value);
          err_count++;
        end
        if (out_key_char !== want.chr) begin
          $error("key_char: expected %0h, got %0h", want.chr, out_key_char);
          err_count++;
        end
        if (out_new_position !== want.pos) begin
          $error("new_position: expected %0d, got %0d", want.pos, out_new_position);
          err_count++;
        end
        if (out_was_decode !== want.dec) begin
          $error("was_decode: expected %0b, got %0b", want.dec, out_was_decode);
          err_count++;
        end
      end
    end
  end

  initial begin
    string key_text;
    cipher_req_t r;
    int idle_pct;
    int counted;
    int rand_items;
    int leftover;
    logic [6:0] seg_len [6];

    err_count = 0;
    checked = 0;
    cycles = 0;
    cur_pos = 0;
    cfg_len = KEY_MAX;
    rand_items = 0;
    key_text = "thequickbrownfoxjumpsoverthelazydog";

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_req_type    <= REQ_LOAD;
    in_new_message <= 1'b0;
    in_key_index   <= '0;
    in_data_byte   <= '0;
    in_code_number <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every slot gets written before anything reads the key
    for (int i = 0; i < KEY_MAX; i++) begin
      r = '{req: REQ_LOAD, nm: 1'b0, kidx: 6'(i), data: 8'(key_text[i % key_text.len()]),
            num: '0};
      send_item(r, 1'b0, '0);
    end

    add_row(typed_row(REQ_ENC, 1'b0, "t", 0, 0, 0, 0, 1'b0));
    add_row(item_row(REQ_ENC, 1'b0, 0, "h", 0));
    add_row(item_row(REQ_ENC, 1'b0, 0, "A", 0));
    add_row(item_row(REQ_ENC, 1'b0, 0, "Z", 0));
    add_row(item_row(REQ_ENC, 1'b0, 0, "z", 0));
    add_row(item_row(REQ_ENC, 1'b0, 0, 8'h40, 0));
    add_row(item_row(REQ_ENC, 1'b0, 0, 8'h5B, 0));
    add_row(item_row(REQ_ENC, 1'b0, 0, 8'h60, 0));
    add_row(item_row(REQ_ENC, 1'b0, 0, 8'h7B, 0));
    add_row(item_row(REQ_ENC, 1'b1, 0, 8'hFF, 0));
    add_row(item_row(REQ_DEC, 1'b0, 0, 0, 0));
    add_row(item_row(REQ_DEC, 1'b0, 0, 0, 64));
    add_row(typed_row(REQ_DEC, 1'b0, 0, 65, 0, CHAR_UNDER, 0, 1'b1));
    add_row(typed_row(REQ_DEC, 1'b1, 0, 127, 0, CHAR_UNDER, 0, 1'b1));
    add_row(item_row(REQ_UNUSED, 1'b1, 6'h3F, 8'hFF, 7'h7F));
    add_row(item_row(REQ_LOAD, 1'b1, 63, 8'hFF, 0));
    add_row(item_row(REQ_DEC, 1'b0, 0, 0, 63));
    add_row(item_row(REQ_ENC, 1'b0, 0, "g", 0));
    add_row(item_row(REQ_DEC, 1'b1, 0, 0, 50));
    add_row(cfg_row(10));
    add_row(item_row(REQ_ENC, 1'b0, 0, "k", 0));
    add_row(typed_row(REQ_ENC, 1'b0, "z", 0, 11, 0, 0, 1'b0));
    add_row(typed_row(REQ_DEC, 1'b0, 0, 11, 0, CHAR_UNDER, 0, 1'b1));
    add_row(item_row(REQ_DEC, 1'b0, 0, 0, 10));
    add_row(cfg_row(0));
    add_row(typed_row(REQ_ENC, 1'b0, "t", 0, 0, 0, 0, 1'b0));
    add_row(typed_row(REQ_ENC, 1'b0, "h", 0, 2, 0, 0, 1'b0));
    add_row(item_row(REQ_DEC, 1'b0, 0, 0, 1));
    add_row(typed_row(REQ_DEC, 1'b0, 0, 2, 0, CHAR_UNDER, 0, 1'b1));
    add_row(cfg_row(127));
    add_row(item_row(REQ_ENC, 1'b1, 0, "G", 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) reconfigure(dir_rows[i].cfg_val);
      else send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);
    end

    seg_len[0] = 7'd64;
    seg_len[1] = 7'd1;
    seg_len[2] = 7'd127;
    seg_len[3] = 7'd0;
    seg_len[4] = 7'($urandom_range(2, 63));
    seg_len[5] = 7'($urandom_range(2, 63));

    for (int seg = 0; seg < 6; seg++) begin
      reconfigure(seg_len[seg]);
      idle_pct = (seg < 2) ? 34 : (seg < 4) ? 71 : 0;
      counted = 0;
      while (counted < SEG_ITEMS) begin
        r = rand_request();
        send_item(r, 1'b0, '0);
        rand_items++;
        counted++;
        if ((seg == 0 && counted == 100) || $urandom_range(0, 99) == 0) begin
          // hold off until every pending result is out
          start <= 1'b0;
          do @(posedge clk); while (cipher_q.size() != 0);
        end else if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end

    drain_block();
    leftover = cipher_q.size();
    if (leftover != 0) $error("%0d expected results never arrived", leftover);

    $display("covered %0d directed rows and %0d random transfers, key lengths 0, 1, 64, 127",
             dir_rows.size(), rand_items);
    $display("and two random lengths; %0d results compared", checked);
    if (err_count == 0 && leftover == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/pkc_pkg.sv
sv/pkc_ctrl.sv
sv/pkc_dp.sv
sv/pangram_key_cipher.sv
sim/tb.sv
